>>> hw/rtl/lrx_pkg.sv
// ----------------------------------------------------------------------------
// lrx_pkg
// shared types and constants of the lidar range to xyz converter
// ----------------------------------------------------------------------------
package lrx_pkg;

  localparam int DEF_COLUMNS = 1024;
  localparam int DEF_ROWS    = 128;

  localparam int RowW   = 7;
  localparam int ColW   = 10;
  localparam int RangeW = 20;
  localparam int DirW   = 16;
  localparam int OffW   = 20;
  localparam int PointW = 26;
  // signed range times signed direction
  localparam int ProdW  = RangeW + 1 + DirW;
  localparam int FracW  = 11;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  // pixel and range of one request
  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   column;
    logic [RangeW-1:0] range_mm;
  } pix_t;

  // one table word: direction and beam offset
  typedef struct packed {
    logic [DirW-1:0] dir_x;
    logic [DirW-1:0] dir_y;
    logic [DirW-1:0] dir_z;
    logic [OffW-1:0] off_x;
    logic [OffW-1:0] off_y;
    logic [OffW-1:0] off_z;
  } entry_t;

endpackage

>>> hw/rtl/lidar_range_to_xyz_converter_top.sv
// ----------------------------------------------------------------------------
// lidar_range_to_xyz_converter_top
// lidar range samples to cartesian points through a per-pixel direction table
// ----------------------------------------------------------------------------
// a convert request shows its point once it has passed all four register stages
// throughput: one request per cycle while no result is held at the output, loads and converts mixed freely
// four register stages: address, table read, multiply, scale and offset add
// loads write the table in the second stage and retire there with no result
// reset clears only the stage valid bits; the table holds no defined value
// until an entry is loaded, there is no clearing pass after reset
module lidar_range_to_xyz_converter_top #(
  parameter int COLUMNS = lrx_pkg::DEF_COLUMNS,
  parameter int ROWS    = lrx_pkg::DEF_ROWS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [lrx_pkg::RowW-1:0]           row_i,
  input  logic [lrx_pkg::ColW-1:0]           column_i,
  input  logic [lrx_pkg::RangeW-1:0]         range_mm_i,
  input  logic signed [lrx_pkg::DirW-1:0]    dir_x_i,
  input  logic signed [lrx_pkg::DirW-1:0]    dir_y_i,
  input  logic signed [lrx_pkg::DirW-1:0]    dir_z_i,
  input  logic signed [lrx_pkg::OffW-1:0]    off_x_i,
  input  logic signed [lrx_pkg::OffW-1:0]    off_y_i,
  input  logic signed [lrx_pkg::OffW-1:0]    off_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [lrx_pkg::PointW-1:0]  point_x_o,
  output logic signed [lrx_pkg::PointW-1:0]  point_y_o,
  output logic signed [lrx_pkg::PointW-1:0]  point_z_o,
  output logic [lrx_pkg::RowW-1:0]           out_row_o,
  output logic [lrx_pkg::ColW-1:0]           out_column_o
);

  localparam int Depth = ROWS * COLUMNS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  lrx_pkg::entry_t wr_entry;
  logic            a_valid;
  logic            a_take;
  logic            a_load;
  logic [AW-1:0]   a_idx;
  lrx_pkg::pix_t   a_pix;
  lrx_pkg::entry_t a_entry;
  logic            b_valid;
  logic            c_ready;
  lrx_pkg::pix_t   b_pix;
  lrx_pkg::entry_t b_entry;

  assign wr_entry = '{dir_x: dir_x_i, dir_y: dir_y_i, dir_z: dir_z_i,
                      off_x: off_x_i, off_y: off_y_i, off_z: off_z_i};

  lrx_index #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_index (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .row_i      (row_i),
    .column_i   (column_i),
    .range_mm_i (range_mm_i),
    .wr_entry_i (wr_entry),
    .valid_o    (a_valid),
    .take_i     (a_take),
    .load_o     (a_load),
    .idx_o      (a_idx),
    .pix_o      (a_pix),
    .entry_o    (a_entry)
  );

  lrx_table #(
    .AW    (AW),
    .DEPTH (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid),
    .take_o  (a_take),
    .load_i  (a_load),
    .idx_i   (a_idx),
    .pix_i   (a_pix),
    .entry_i (a_entry),
    .valid_o (b_valid),
    .ready_i (c_ready),
    .pix_o   (b_pix),
    .entry_o (b_entry)
  );

  lrx_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (b_valid),
    .ready_o      (c_ready),
    .pix_i        (b_pix),
    .entry_i      (b_entry),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .point_z_o    (point_z_o),
    .out_row_o    (out_row_o),
    .out_column_o (out_column_o)
  );

  // back pressure only starts from a held result at the output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output side was free");

endmodule

>>> hw/rtl/lrx_index.sv
// ----------------------------------------------------------------------------
// lrx_index
// input stage: pixel range check and table address calculation
// ----------------------------------------------------------------------------
module lrx_index #(
  parameter int COLUMNS = lrx_pkg::DEF_COLUMNS,
  parameter int ROWS    = lrx_pkg::DEF_ROWS,
  parameter int AW      = 17
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [lrx_pkg::RowW-1:0]    row_i,
  input  logic [lrx_pkg::ColW-1:0]    column_i,
  input  logic [lrx_pkg::RangeW-1:0]  range_mm_i,
  input  lrx_pkg::entry_t             wr_entry_i,
  output logic                        valid_o,
  input  logic                        take_i,
  output logic                        load_o,
  output logic [AW-1:0]               idx_o,
  output lrx_pkg::pix_t               pix_o,
  output lrx_pkg::entry_t             entry_o
);

  logic            valid_q;
  logic            load_q;
  logic [AW-1:0]   idx_q;
  lrx_pkg::pix_t   pix_q;
  lrx_pkg::entry_t entry_q;

  logic            in_range;
  logic [AW-1:0]   idx_d;
  logic            advance;

  assign in_range = (32'(row_i) < 32'(ROWS)) && (32'(column_i) < 32'(COLUMNS));
  assign idx_d    = AW'(32'(row_i) * 32'(COLUMNS) + 32'(column_i));
  assign advance  = !valid_q || take_i;
  assign in_stall_o = !advance;

  // out of range pixels are dropped here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_valid_i && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      load_q   <= (opcode_i == lrx_pkg::OP_LOAD);
      idx_q    <= idx_d;
      pix_q    <= '{row: row_i, column: column_i, range_mm: range_mm_i};
      entry_q  <= wr_entry_i;
    end
  end

  assign valid_o = valid_q;
  assign load_o  = load_q;
  assign idx_o   = idx_q;
  assign pix_o   = pix_q;
  assign entry_o = entry_q;

  a_drop_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !in_range) |=> !valid_q)
    else $error("out of range pixel entered the pipeline");

endmodule

>>> hw/rtl/lrx_table.sv
// ----------------------------------------------------------------------------
// lrx_table
// per-pixel direction and offset table, written by loads, read by converts
// ----------------------------------------------------------------------------
module lrx_table #(
  parameter int AW    = 17,
  parameter int DEPTH = 131072
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            take_o,
  input  logic            load_i,
  input  logic [AW-1:0]   idx_i,
  input  lrx_pkg::pix_t   pix_i,
  input  lrx_pkg::entry_t entry_i,
  output logic            valid_o,
  input  logic            ready_i,
  output lrx_pkg::pix_t   pix_o,
  output lrx_pkg::entry_t entry_o
);

  lrx_pkg::entry_t mem [DEPTH];

  logic            valid_q;
  lrx_pkg::pix_t   pix_q;
  lrx_pkg::entry_t rdata_q;
  logic            ready_b;
  logic            rd_en;

  assign ready_b = !valid_q || ready_i;
  // a load retires on its write and never waits for the stages behind
  assign take_o  = load_i || ready_b;
  assign rd_en   = ready_b && valid_i && !load_i;

  always_ff @(posedge clk_i) begin
    if (valid_i && load_i) begin
      mem[idx_i] <= entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[idx_i];
      pix_q   <= pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_b) begin
      valid_q <= valid_i && !load_i;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;
  assign entry_o = rdata_q;

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && load_i && ready_b) |=> !valid_q)
    else $error("load request produced a table read result");

endmodule

>>> hw/rtl/lrx_mac.sv
// ----------------------------------------------------------------------------
// lrx_mac
// one stage of three multipliers, then the scale and offset add with output register
// ----------------------------------------------------------------------------
module lrx_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  lrx_pkg::pix_t                      pix_i,
  input  lrx_pkg::entry_t                    entry_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [lrx_pkg::PointW-1:0]  point_x_o,
  output logic signed [lrx_pkg::PointW-1:0]  point_y_o,
  output logic signed [lrx_pkg::PointW-1:0]  point_z_o,
  output logic [lrx_pkg::RowW-1:0]           out_row_o,
  output logic [lrx_pkg::ColW-1:0]           out_column_o
);

  logic                              valid_c_q;
  logic                              valid_d_q;
  logic                              ready_c;
  logic                              ready_d;

  logic signed [lrx_pkg::RangeW:0]   rng_s;
  logic signed [lrx_pkg::ProdW-1:0]  prod_x_d, prod_y_d, prod_z_d;
  logic signed [lrx_pkg::ProdW-1:0]  prod_x_q, prod_y_q, prod_z_q;
  logic signed [lrx_pkg::OffW-1:0]   off_x_q, off_y_q, off_z_q;
  logic [lrx_pkg::RowW-1:0]          row_c_q;
  logic [lrx_pkg::ColW-1:0]          col_c_q;

  logic signed [lrx_pkg::PointW-1:0] point_x_d, point_y_d, point_z_d;
  logic signed [lrx_pkg::PointW-1:0] point_x_q, point_y_q, point_z_q;
  logic [lrx_pkg::RowW-1:0]          row_d_q;
  logic [lrx_pkg::ColW-1:0]          col_d_q;

  assign ready_d = !valid_d_q || !out_stall_i;
  assign ready_c = !valid_c_q || ready_d;
  assign ready_o = ready_c;

  // range is unsigned, widened by one zero bit for a signed product
  assign rng_s    = $signed({1'b0, pix_i.range_mm});
  assign prod_x_d = rng_s * $signed(entry_i.dir_x);
  assign prod_y_d = rng_s * $signed(entry_i.dir_y);
  assign prod_z_d = rng_s * $signed(entry_i.dir_z);

  always_ff @(posedge clk_i) begin
    if (ready_c && valid_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
      off_x_q  <= $signed(entry_i.off_x);
      off_y_q  <= $signed(entry_i.off_y);
      off_z_q  <= $signed(entry_i.off_z);
      row_c_q  <= pix_i.row;
      col_c_q  <= pix_i.column;
    end
  end

  // dropping the low bits of a two's complement product is a floor shift
  assign point_x_d = prod_x_q[lrx_pkg::ProdW-1:lrx_pkg::FracW] + lrx_pkg::PointW'(off_x_q);
  assign point_y_d = prod_y_q[lrx_pkg::ProdW-1:lrx_pkg::FracW] + lrx_pkg::PointW'(off_y_q);
  assign point_z_d = prod_z_q[lrx_pkg::ProdW-1:lrx_pkg::FracW] + lrx_pkg::PointW'(off_z_q);

  always_ff @(posedge clk_i) begin
    if (ready_d && valid_c_q) begin
      point_x_q <= point_x_d;
      point_y_q <= point_y_d;
      point_z_q <= point_z_d;
      row_d_q   <= row_c_q;
      col_d_q   <= col_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else begin
      if (ready_c) begin
        valid_c_q <= valid_i;
      end
      if (ready_d) begin
        valid_d_q <= valid_c_q;
      end
    end
  end

  assign out_valid_o  = valid_d_q;
  assign point_x_o    = point_x_q;
  assign point_y_o    = point_y_q;
  assign point_z_o    = point_z_q;
  assign out_row_o    = row_d_q;
  assign out_column_o = col_d_q;

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_d_q) |-> $past(valid_c_q))
    else $error("result appeared without a product in the multiply stage");

endmodule

>>> sim/lidar_range_to_xyz_converter_top_tb.sv
// ----------------------------------------------------------------------------
// lidar_range_to_xyz_converter_top_tb
// loads per-pixel direction and offset entries, interleaved with conversions of range samples
// of loaded pixels, and checks every point against a scoreboard kept in step with the table
// ----------------------------------------------------------------------------
module lidar_range_to_xyz_converter_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS   = lrx_pkg::DEF_COLUMNS;
  localparam int ROWS      = lrx_pkg::DEF_ROWS;
  localparam int MAX_IDLE  = 15;
  localparam logic [lrx_pkg::RangeW-1:0] RANGE_MAX = '1;

  typedef struct {
    logic                       opcode;
    lrx_pkg::pix_t              pix;
    lrx_pkg::entry_t            ent;
  } request_t;

  typedef struct {
    logic signed [lrx_pkg::PointW-1:0] x;
    logic signed [lrx_pkg::PointW-1:0] y;
    logic signed [lrx_pkg::PointW-1:0] z;
    logic [lrx_pkg::RowW-1:0]          row;
    logic [lrx_pkg::ColW-1:0]          column;
  } point_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic                              opcode_i;
  logic [lrx_pkg::RowW-1:0]          row_i;
  logic [lrx_pkg::ColW-1:0]          column_i;
  logic [lrx_pkg::RangeW-1:0]        range_mm_i;
  logic signed [lrx_pkg::DirW-1:0]   dir_x_i;
  logic signed [lrx_pkg::DirW-1:0]   dir_y_i;
  logic signed [lrx_pkg::DirW-1:0]   dir_z_i;
  logic signed [lrx_pkg::OffW-1:0]   off_x_i;
  logic signed [lrx_pkg::OffW-1:0]   off_y_i;
  logic signed [lrx_pkg::OffW-1:0]   off_z_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [lrx_pkg::PointW-1:0] point_x_o;
  logic signed [lrx_pkg::PointW-1:0] point_y_o;
  logic signed [lrx_pkg::PointW-1:0] point_z_o;
  logic [lrx_pkg::RowW-1:0]          out_row_o;
  logic [lrx_pkg::ColW-1:0]          out_column_o;

  // scoreboard state
  lrx_pkg::entry_t pixel_table [int];
  int              loaded_pixels [$];
  int              last_loaded;
  point_t          pending_points [$];

  bit sender_gaps = 1'b0;
  bit sink_stalls = 1'b0;

  int n_loads    = 0;
  int n_converts = 0;
  int n_checked  = 0;
  int n_errors   = 0;

  lidar_range_to_xyz_converter_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .range_mm_i  (range_mm_i),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .off_x_i     (off_x_i),
    .off_y_i     (off_y_i),
    .off_z_i     (off_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .out_row_o   (out_row_o),
    .out_column_o(out_column_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // floor((range * dir) / 2^11) + offset, wrapped to the point width
  function automatic logic signed [lrx_pkg::PointW-1:0] scale_axis(
    input logic [lrx_pkg::RangeW-1:0]      range_mm,
    input logic signed [lrx_pkg::DirW-1:0] dir,
    input logic signed [lrx_pkg::OffW-1:0] off
  );
    longint prod;
    prod = longint'(range_mm) * longint'(dir);
    prod = prod >>> lrx_pkg::FracW;
    prod = prod + longint'(off);
    return prod[lrx_pkg::PointW-1:0];
  endfunction

  function automatic logic [lrx_pkg::DirW-1:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(lrx_pkg::DirW-1){1'b0}}};
      1: return {1'b0, {(lrx_pkg::DirW-1){1'b1}}};
      2: return '0;
      default: return lrx_pkg::DirW'($urandom);
    endcase
  endfunction

  function automatic logic [lrx_pkg::OffW-1:0] rand_off();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(lrx_pkg::OffW-1){1'b0}}};
      1: return {1'b0, {(lrx_pkg::OffW-1){1'b1}}};
      2: return '0;
      default: return lrx_pkg::OffW'($urandom);
    endcase
  endfunction

  function automatic lrx_pkg::entry_t rand_entry();
    lrx_pkg::entry_t e;
    e.dir_x = rand_dir();
    e.dir_y = rand_dir();
    e.dir_z = rand_dir();
    e.off_x = rand_off();
    e.off_y = rand_off();
    e.off_z = rand_off();
    return e;
  endfunction

  function automatic logic [lrx_pkg::RangeW-1:0] rand_range();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RANGE_MAX;
      default: return lrx_pkg::RangeW'($urandom);
    endcase
  endfunction

  // a small corner of the table is hit often so entries get overwritten
  function automatic int pick_pixel();
    int r;
    int c;
    r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, ROWS-1);
    c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, COLUMNS-1);
    return r * COLUMNS + c;
  endfunction

  // range field is junk on a load
  function automatic request_t load_req(input int idx, input lrx_pkg::entry_t ent);
    request_t req;
    req.opcode       = lrx_pkg::OP_LOAD;
    req.pix.row      = lrx_pkg::RowW'(idx / COLUMNS);
    req.pix.column   = lrx_pkg::ColW'(idx % COLUMNS);
    req.pix.range_mm = lrx_pkg::RangeW'($urandom);
    req.ent          = ent;
    return req;
  endfunction

  // table fields are junk on a convert
  function automatic request_t convert_req(input int idx,
                                           input logic [lrx_pkg::RangeW-1:0] range_mm);
    request_t req;
    req.opcode       = lrx_pkg::OP_CONVERT;
    req.pix.row      = lrx_pkg::RowW'(idx / COLUMNS);
    req.pix.column   = lrx_pkg::ColW'(idx % COLUMNS);
    req.pix.range_mm = range_mm;
    req.ent          = rand_entry();
    return req;
  endfunction

  function automatic lrx_pkg::entry_t make_entry(
    input logic [lrx_pkg::DirW-1:0] dx, input logic [lrx_pkg::DirW-1:0] dy,
    input logic [lrx_pkg::DirW-1:0] dz,
    input logic [lrx_pkg::OffW-1:0] ox, input logic [lrx_pkg::OffW-1:0] oy,
    input logic [lrx_pkg::OffW-1:0] oz
  );
    lrx_pkg::entry_t e;
    e.dir_x = dx;
    e.dir_y = dy;
    e.dir_z = dz;
    e.off_x = ox;
    e.off_y = oy;
    e.off_z = oz;
    return e;
  endfunction

  task automatic send_request(input request_t req);
    int              gap;
    int              idx;
    point_t          pt;
    lrx_pkg::entry_t e;
    gap = sender_gaps ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= req.opcode;
    row_i      <= req.pix.row;
    column_i   <= req.pix.column;
    range_mm_i <= req.pix.range_mm;
    dir_x_i    <= req.ent.dir_x;
    dir_y_i    <= req.ent.dir_y;
    dir_z_i    <= req.ent.dir_z;
    off_x_i    <= req.ent.off_x;
    off_y_i    <= req.ent.off_y;
    off_z_i    <= req.ent.off_z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // request accepted, bring the table copy up to date
    if (req.pix.row < ROWS && req.pix.column < COLUMNS) begin
      idx = int'(req.pix.row) * COLUMNS + int'(req.pix.column);
      if (req.opcode == lrx_pkg::OP_LOAD) begin
        if (!pixel_table.exists(idx)) loaded_pixels.push_back(idx);
        pixel_table[idx] = req.ent;
        last_loaded = idx;
        n_loads++;
      end else begin
        e         = pixel_table[idx];
        pt.x      = scale_axis(req.pix.range_mm, e.dir_x, e.off_x);
        pt.y      = scale_axis(req.pix.range_mm, e.dir_y, e.off_y);
        pt.z      = scale_axis(req.pix.range_mm, e.dir_z, e.off_z);
        pt.row    = req.pix.row;
        pt.column = req.pix.column;
        pending_points.push_back(pt);
        n_converts++;
      end
    end
  endtask

  task automatic wait_for_points();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_points.size() != 0);
  endtask

  // random loads and converts of written pixels, with the most recent load favored
  task automatic run_stream(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (loaded_pixels.size() == 0 || $urandom_range(0, 99) < 40) begin
        send_request(load_req(pick_pixel(), rand_entry()));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          pick = last_loaded;
        end else begin
          pick = loaded_pixels[$urandom_range(0, loaded_pixels.size()-1)];
        end
        send_request(convert_req(pick, rand_range()));
      end
    end
  endtask

  task automatic test_table_extremes();
    int p_lo;
    int p_hi;
    int p_mid;
    p_lo  = 0;
    p_hi  = (ROWS - 1) * COLUMNS + (COLUMNS - 1);
    p_mid = (ROWS / 2) * COLUMNS + COLUMNS / 2;
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    send_request(load_req(p_lo, make_entry(16'h8000, 16'h8000, 16'h8000,
                                           20'h80000, 20'h80000, 20'h80000)));
    send_request(load_req(p_hi, make_entry(16'h7fff, 16'h7fff, 16'h7fff,
                                           20'h7ffff, 20'h7ffff, 20'h7ffff)));
    send_request(load_req(p_mid, make_entry(16'h7fff, 16'h8000, 16'h0000,
                                            20'h00000, 20'hfffff, 20'h00001)));
    send_request(convert_req(p_lo, '0));
    send_request(convert_req(p_lo, RANGE_MAX));
    send_request(convert_req(p_lo, 20'd1));
    send_request(convert_req(p_hi, RANGE_MAX));
    send_request(convert_req(p_hi, 20'd1));
    send_request(convert_req(p_hi, '0));
    send_request(convert_req(p_mid, RANGE_MAX));
    send_request(convert_req(p_mid, 20'd1));
    // a range just under 2^11 and a power-of-two range against extreme directions check the floor
    send_request(convert_req(p_mid, 20'd2047));
    send_request(convert_req(p_mid, 20'h80000));
    // overwrite then read straight behind the write
    send_request(load_req(p_lo, make_entry(16'h4000, 16'hc000, 16'h0001,
                                           20'h12345, 20'hedcba, 20'h00000)));
    send_request(convert_req(p_lo, RANGE_MAX));
    send_request(load_req(p_hi, rand_entry()));
    send_request(convert_req(p_hi, rand_range()));
    send_request(convert_req(p_hi, rand_range()));
    send_request(load_req(p_mid, rand_entry()));
    send_request(convert_req(p_mid, RANGE_MAX));
    wait_for_points();
  endtask

  task automatic test_mixed_traffic();
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    run_stream(450);
  endtask

  task automatic test_full_rate();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    run_stream(200);
  endtask

  task automatic test_drain_pause();
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    for (int i = 0; i < 4; i++) begin
      run_stream(50);
      wait_for_points();
    end
  endtask

  // output side: a fresh random stall before each point
  always begin : sink
    int hold;
    hold = sink_stalls ? $urandom_range(0, MAX_IDLE) : 0;
    if (hold > 0) begin
      out_stall_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
    end
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    while (!out_valid_o) @(posedge clk_i);
  end

  task automatic check_point();
    point_t want;
    if (pending_points.size() == 0) begin
      $error("unexpected point at row %0d column %0d", out_row_o, out_column_o);
      n_errors++;
    end else begin
      want = pending_points.pop_front();
      n_checked++;
      if (point_x_o !== want.x) begin
        $error("point_x expected %0d actual %0d", want.x, point_x_o);
        n_errors++;
      end
      if (point_y_o !== want.y) begin
        $error("point_y expected %0d actual %0d", want.y, point_y_o);
        n_errors++;
      end
      if (point_z_o !== want.z) begin
        $error("point_z expected %0d actual %0d", want.z, point_z_o);
        n_errors++;
      end
      if (out_row_o !== want.row) begin
        $error("out_row expected %0d actual %0d", want.row, out_row_o);
        n_errors++;
      end
      if (out_column_o !== want.column) begin
        $error("out_column expected %0d actual %0d", want.column, out_column_o);
        n_errors++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) check_point();
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    opcode_i   <= lrx_pkg::OP_CONVERT;
    row_i      <= '0;
    column_i   <= '0;
    range_mm_i <= '0;
    dir_x_i    <= '0;
    dir_y_i    <= '0;
    dir_z_i    <= '0;
    off_x_i    <= '0;
    off_y_i    <= '0;
    off_z_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_extremes();
    test_mixed_traffic();
    test_full_rate();
    test_drain_pause();
    wait_for_points();
    repeat (16) @(posedge clk_i);
    $display("run covered %0d table loads and %0d conversions, %0d points checked,",
             n_loads, n_converts, n_checked);
    $display("with full-rate stretches and random gaps and stalls on both sides");
    if (n_errors == 0) begin
      $display("lidar_range_to_xyz_converter_top_tb passed");
    end else begin
      $display("lidar_range_to_xyz_converter_top_tb failed");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("timeout with %0d points outstanding", pending_points.size());
    $display("lidar_range_to_xyz_converter_top_tb failed");
    $finish;
  end

endmodule
